>>> src/nfc_pkg.sv
// Shared constants, types and control/status structs for the NOR flash
// command interface. No dependencies.
package nfc_pkg;

   localparam int ADDR_W = 17;
   localparam int DATA_W = 32;
   localparam int PHASE_W = 3;

   localparam int MEM_WORDS_DEFAULT = 131072;
   localparam int SECTOR_WORDS_DEFAULT = 32768;

   localparam logic [DATA_W-1:0] DEVICE_ID_RESET = 32'h227e_227e;

   localparam logic [DATA_W-1:0] CMD_UNLOCK1 = 32'h00aa_00aa;
   localparam logic [DATA_W-1:0] CMD_UNLOCK2 = 32'h0055_0055;
   localparam logic [DATA_W-1:0] CMD_PROGRAM = 32'h00a0_00a0;
   localparam logic [DATA_W-1:0] CMD_ERASE = 32'h0080_0080;
   localparam logic [DATA_W-1:0] CMD_SECTOR = 32'h0030_0030;
   localparam logic [DATA_W-1:0] CMD_AUTOSEL = 32'h0090_0090;
   localparam logic [DATA_W-1:0] CMD_RESET = 32'h00f0_00f0;

   localparam logic [ADDR_W-1:0] ADDR_FIRST = 17'h00555;
   localparam logic [ADDR_W-1:0] ADDR_SECOND = 17'h002aa;
   localparam logic [ADDR_W-1:0] ADDR_ID = 17'h00001;

   typedef enum logic [PHASE_W-1:0] {
      PH_READ = 3'd0,
      PH_UNLOCK1 = 3'd1,
      PH_UNLOCK2 = 3'd2,
      PH_PROGRAM = 3'd3,
      PH_ERASE_SETUP = 3'd4,
      PH_ERASE_UNLOCK = 3'd5,
      PH_AUTOSELECT = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_MEM,
      RSP_ID
   } rsp_src_type;

   typedef struct packed {
      logic mode;
      logic [ADDR_W-1:0] word_address;
      logic [DATA_W-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [PHASE_W-1:0] command_phase;
   } rsp_payload_type;

   typedef struct packed {
      logic req_ready;
      logic mem_read;
      logic pgm_write;
      logic walk_step;
      logic locate_start;
      logic locate_step;
      logic rsp_load;
      rsp_src_type rsp_src;
      phase_type rsp_phase;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic mode;
      logic addr_first;
      logic addr_second;
      logic addr_id;
      logic data_unlock1;
      logic data_unlock2;
      logic data_program;
      logic data_erase;
      logic data_sector;
      logic data_autosel;
      logic walk_done;
      logic locate_done;
      logic rsp_free;
   } dp_status_type;

endpackage

>>> src/nfc_if.sv
// Request and response channel interfaces: valid/ready handshake plus payload.
// Depends on nfc_pkg.
interface nfc_req_if;
   logic valid;
   logic ready;
   nfc_pkg::req_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface nfc_rsp_if;
   logic valid;
   logic ready;
   nfc_pkg::rsp_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

>>> src/nor_flash_command_interface.sv
// Top level of the NOR flash command interface: controller plus datapath.
// Depends on nfc_pkg, nfc_if, nfc_ctrl, nfc_datapath.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        mode, word_address, write_data
//   rsp      out        valid/ready        read_data, command_phase
//   csr      in         csr_write_enable   csr_write_data (device ID)
//
// Reads and commands pass DECODE then PUSH into the response register; program adds PROGRAM.
// Sector erase walks LOCATE to find the sector base, then ERASE clears one array word
// per cycle through the single write port.
// After reset the array is swept to all ones; req ready stays low until the sweep ends.
// A waiting response holds the next result back; one request is in flight at a time.
module nor_flash_command_interface #(
   parameter int MEM_WORDS = nfc_pkg::MEM_WORDS_DEFAULT,
   parameter int SECTOR_WORDS = nfc_pkg::SECTOR_WORDS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   nfc_req_if.sink                    req_if,
   nfc_rsp_if.source                  rsp_if,
   input  logic                       csr_write_enable,
   input  logic [nfc_pkg::DATA_W-1:0] csr_write_data
);

   nfc_pkg::ctrl_cmd_type cmd;
   nfc_pkg::dp_status_type status;

   nfc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   nfc_datapath #(
      .MEM_WORDS    (MEM_WORDS),
      .SECTOR_WORDS (SECTOR_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> src/nfc_ctrl.sv
// Command decoder and sequencer: unlock/command phase tracking, erase and
// clear sweeps, response hand-off. Depends on nfc_pkg.
module nfc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  nfc_pkg::dp_status_type status,
   output nfc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PROGRAM,
      ST_LOCATE,
      ST_ERASE,
      ST_PUSH
   } state_type;

   state_type state_ff, state_in;
   nfc_pkg::phase_type phase_ff, phase_in;
   logic seen_ff, seen_in;
   logic auto_ff, auto_in;
   nfc_pkg::rsp_src_type src_ff, src_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      seen_in = seen_ff;
      auto_in = auto_ff;
      src_in = src_ff;
      cmd = '0;
      cmd.rsp_src = src_ff;
      cmd.rsp_phase = phase_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_fire) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_PUSH;
            if (!status.mode) begin
               cmd.mem_read = 1'b1;
               src_in = (auto_ff && status.addr_id) ? nfc_pkg::RSP_ID : nfc_pkg::RSP_MEM;
            end else begin
               src_in = nfc_pkg::RSP_ZERO;
               phase_in = nfc_pkg::PH_READ;
               seen_in = 1'b0;
               auto_in = 1'b0;
               case (phase_ff)
                  nfc_pkg::PH_READ, nfc_pkg::PH_AUTOSELECT: begin
                     if (status.addr_first && status.data_unlock1) begin
                        phase_in = nfc_pkg::PH_UNLOCK1;
                        auto_in = auto_ff;
                     end
                  end
                  nfc_pkg::PH_UNLOCK1: begin
                     if (status.addr_second && status.data_unlock2) begin
                        phase_in = nfc_pkg::PH_UNLOCK2;
                        auto_in = auto_ff;
                     end
                  end
                  nfc_pkg::PH_UNLOCK2: begin
                     if (status.addr_first && status.data_program) begin
                        phase_in = nfc_pkg::PH_PROGRAM;
                     end else if (status.addr_first && status.data_erase) begin
                        phase_in = nfc_pkg::PH_ERASE_SETUP;
                     end else if (status.addr_first && status.data_autosel) begin
                        phase_in = nfc_pkg::PH_AUTOSELECT;
                        auto_in = 1'b1;
                     end
                  end
                  nfc_pkg::PH_PROGRAM: begin
                     cmd.mem_read = 1'b1;
                     state_in = ST_PROGRAM;
                  end
                  nfc_pkg::PH_ERASE_SETUP: begin
                     if (!seen_ff && status.addr_first && status.data_unlock1) begin
                        phase_in = nfc_pkg::PH_ERASE_SETUP;
                        seen_in = 1'b1;
                        auto_in = auto_ff;
                     end else if (seen_ff && status.addr_second && status.data_unlock2) begin
                        phase_in = nfc_pkg::PH_ERASE_UNLOCK;
                        auto_in = auto_ff;
                     end
                  end
                  nfc_pkg::PH_ERASE_UNLOCK: begin
                     if (status.data_sector) begin
                        cmd.locate_start = 1'b1;
                        state_in = ST_LOCATE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROGRAM: begin
            cmd.pgm_write = 1'b1;
            state_in = ST_PUSH;
         end
         ST_LOCATE: begin
            cmd.locate_step = 1'b1;
            if (status.locate_done) begin
               state_in = ST_ERASE;
            end
         end
         ST_ERASE: begin
            if (status.walk_done) begin
               state_in = ST_PUSH;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_PUSH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= nfc_pkg::PH_READ;
         seen_ff <= 1'b0;
         auto_ff <= 1'b0;
         src_ff <= nfc_pkg::RSP_ZERO;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         seen_ff <= seen_in;
         auto_ff <= auto_in;
         src_ff <= src_in;
      end
   end

endmodule

>>> src/nfc_datapath.sv
// Request capture, word index reduction, flash array, sector sweep pointer,
// device ID register and response register. Depends on nfc_pkg, nfc_if.
module nfc_datapath #(
   parameter int MEM_WORDS = nfc_pkg::MEM_WORDS_DEFAULT,
   parameter int SECTOR_WORDS = nfc_pkg::SECTOR_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   nfc_req_if.sink                            req_if,
   nfc_rsp_if.source                          rsp_if,
   input  logic                               csr_write_enable,
   input  logic [nfc_pkg::DATA_W-1:0]         csr_write_data,
   input  nfc_pkg::ctrl_cmd_type              cmd,
   output nfc_pkg::dp_status_type             status
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int PW = $clog2(MEM_WORDS + SECTOR_WORDS + 1);
   localparam int XW = ((AW > nfc_pkg::ADDR_W) ? AW : nfc_pkg::ADDR_W) + 2;
   localparam logic [XW-1:0] MEM_X1 = XW'(MEM_WORDS);
   localparam logic [XW-1:0] MEM_X2 = XW'(2 * MEM_WORDS);
   localparam logic [XW-1:0] MEM_X3 = XW'(3 * MEM_WORDS);
   localparam logic [PW-1:0] MEM_P = PW'(MEM_WORDS);
   localparam logic [PW-1:0] SECTOR_P = PW'(SECTOR_WORDS);

   nfc_pkg::req_payload_type req_ff;
   logic [nfc_pkg::DATA_W-1:0] mem_ff [MEM_WORDS];
   logic [nfc_pkg::DATA_W-1:0] mem_q_ff;
   logic [nfc_pkg::DATA_W-1:0] device_id_ff;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] stop_ff, stop_in;
   logic rsp_valid_ff, rsp_valid_in;
   nfc_pkg::rsp_payload_type rsp_ff;

   logic req_fire;
   logic [XW-1:0] addr_x;
   logic [XW-1:0] idx_x;
   logic [AW-1:0] idx;
   logic [PW-1:0] next_base;
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic [nfc_pkg::DATA_W-1:0] mem_wdata;
   logic [nfc_pkg::DATA_W-1:0] rsp_data;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_if.payload;
      end
   end

   always_comb begin
      addr_x = XW'(req_ff.word_address);
      if (addr_x >= MEM_X3) begin
         idx_x = addr_x - MEM_X3;
      end else if (addr_x >= MEM_X2) begin
         idx_x = addr_x - MEM_X2;
      end else if (addr_x >= MEM_X1) begin
         idx_x = addr_x - MEM_X1;
      end else begin
         idx_x = addr_x;
      end
   end

   assign idx = idx_x[AW-1:0];
   assign next_base = ptr_ff + SECTOR_P;

   always_comb begin
      ptr_in = ptr_ff;
      stop_in = stop_ff;
      if (cmd.locate_start) begin
         ptr_in = '0;
      end else if (cmd.locate_step) begin
         if (next_base <= PW'(idx)) begin
            ptr_in = next_base;
         end else begin
            stop_in = (next_base > MEM_P) ? MEM_P : next_base;
         end
      end else if (cmd.walk_step) begin
         ptr_in = ptr_ff + PW'(1);
      end
   end

   assign mem_we = cmd.walk_step || cmd.pgm_write;
   assign mem_waddr = cmd.walk_step ? ptr_ff[AW-1:0] : idx;
   assign mem_wdata = cmd.walk_step ? '1 : (mem_q_ff & req_ff.write_data);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         mem_q_ff <= mem_ff[idx];
      end
   end

   always_comb begin
      case (cmd.rsp_src)
         nfc_pkg::RSP_MEM: rsp_data = mem_q_ff;
         nfc_pkg::RSP_ID: rsp_data = device_id_ff;
         default: rsp_data = '0;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         stop_ff <= MEM_P;
         rsp_valid_ff <= 1'b0;
         device_id_ff <= nfc_pkg::DEVICE_ID_RESET;
      end else begin
         ptr_ff <= ptr_in;
         stop_ff <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            device_id_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.read_data <= rsp_data;
         rsp_ff.command_phase <= cmd.rsp_phase;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign status.req_fire = req_fire;
   assign status.mode = req_ff.mode;
   assign status.addr_first = (req_ff.word_address == nfc_pkg::ADDR_FIRST);
   assign status.addr_second = (req_ff.word_address == nfc_pkg::ADDR_SECOND);
   assign status.addr_id = (req_ff.word_address == nfc_pkg::ADDR_ID);
   assign status.data_unlock1 = (req_ff.write_data == nfc_pkg::CMD_UNLOCK1);
   assign status.data_unlock2 = (req_ff.write_data == nfc_pkg::CMD_UNLOCK2);
   assign status.data_program = (req_ff.write_data == nfc_pkg::CMD_PROGRAM);
   assign status.data_erase = (req_ff.write_data == nfc_pkg::CMD_ERASE);
   assign status.data_sector = (req_ff.write_data == nfc_pkg::CMD_SECTOR);
   assign status.data_autosel = (req_ff.write_data == nfc_pkg::CMD_AUTOSEL);
   assign status.walk_done = (ptr_ff == stop_ff);
   assign status.locate_done = (next_base > PW'(idx));
   assign status.rsp_free = !rsp_valid_ff || rsp_if.ready;

endmodule

>>> bench/tb.sv
// Testbench for nor_flash_command_interface: directed command sequences, then random
// accesses checked against a behavioral model of the flash array and command decoder.
// Depends on nfc_pkg, nfc_if and the block under test.
`timescale 1ns / 1ps

module tb;

   localparam int ARRAY_WORDS = nfc_pkg::MEM_WORDS_DEFAULT;
   localparam int SECTOR_SPAN = nfc_pkg::SECTOR_WORDS_DEFAULT;
   localparam int PHASE_ITEMS = 360;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 100000;

   typedef struct {
      bit fixed;
      nfc_pkg::req_payload_type acc;
      nfc_pkg::rsp_payload_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [nfc_pkg::DATA_W-1:0] csr_write_data;

   nfc_req_if req_ch();
   nfc_rsp_if rsp_ch();

   nor_flash_command_interface dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   logic [nfc_pkg::DATA_W-1:0] flash_mem [ARRAY_WORDS];
   nfc_pkg::phase_type cur_phase;
   bit erase_aa_seen;
   bit id_mode;
   logic [nfc_pkg::DATA_W-1:0] device_id;

   nfc_pkg::rsp_payload_type expect_q[$];
   bit steady;
   bit hold_pending;
   int erases_left;
   int items_sent;
   int errors;
   int n_checked;
   int n_reads;
   int n_writes;
   int n_programs;
   int n_erases;
   int n_id_reads;
   int n_id_writes;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Timeout: %0d responses still outstanding", expect_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void drop_to_read();
      cur_phase = nfc_pkg::PH_READ;
      erase_aa_seen = 1'b0;
      id_mode = 1'b0;
   endfunction

   function automatic nfc_pkg::rsp_payload_type flash_access(nfc_pkg::req_payload_type acc);
      nfc_pkg::rsp_payload_type r;
      int idx;
      int base;
      int i;
      logic [nfc_pkg::ADDR_W-1:0] a;
      logic [nfc_pkg::DATA_W-1:0] d;
      a = acc.word_address;
      d = acc.write_data;
      idx = int'(a) % ARRAY_WORDS;
      r.read_data = '0;
      if (!acc.mode) begin
         n_reads++;
         if (id_mode && a == nfc_pkg::ADDR_ID) begin
            r.read_data = device_id;
            n_id_reads++;
         end else begin
            r.read_data = flash_mem[idx];
         end
      end else begin
         n_writes++;
         case (cur_phase)
            nfc_pkg::PH_READ, nfc_pkg::PH_AUTOSELECT: begin
               if (a == nfc_pkg::ADDR_FIRST && d == nfc_pkg::CMD_UNLOCK1)
                  cur_phase = nfc_pkg::PH_UNLOCK1;
               else drop_to_read();
            end
            nfc_pkg::PH_UNLOCK1: begin
               if (a == nfc_pkg::ADDR_SECOND && d == nfc_pkg::CMD_UNLOCK2)
                  cur_phase = nfc_pkg::PH_UNLOCK2;
               else drop_to_read();
            end
            nfc_pkg::PH_UNLOCK2: begin
               if (a == nfc_pkg::ADDR_FIRST && d == nfc_pkg::CMD_PROGRAM) begin
                  cur_phase = nfc_pkg::PH_PROGRAM;
                  id_mode = 1'b0;
               end else if (a == nfc_pkg::ADDR_FIRST && d == nfc_pkg::CMD_ERASE) begin
                  cur_phase = nfc_pkg::PH_ERASE_SETUP;
                  erase_aa_seen = 1'b0;
                  id_mode = 1'b0;
               end else if (a == nfc_pkg::ADDR_FIRST && d == nfc_pkg::CMD_AUTOSEL) begin
                  cur_phase = nfc_pkg::PH_AUTOSELECT;
                  id_mode = 1'b1;
               end else begin
                  drop_to_read();
               end
            end
            nfc_pkg::PH_PROGRAM: begin
               flash_mem[idx] &= d;
               n_programs++;
               drop_to_read();
            end
            nfc_pkg::PH_ERASE_SETUP: begin
               if (!erase_aa_seen && a == nfc_pkg::ADDR_FIRST
                   && d == nfc_pkg::CMD_UNLOCK1) begin
                  erase_aa_seen = 1'b1;
               end else if (erase_aa_seen && a == nfc_pkg::ADDR_SECOND
                            && d == nfc_pkg::CMD_UNLOCK2) begin
                  cur_phase = nfc_pkg::PH_ERASE_UNLOCK;
                  erase_aa_seen = 1'b0;
               end else begin
                  drop_to_read();
               end
            end
            nfc_pkg::PH_ERASE_UNLOCK: begin
               if (d == nfc_pkg::CMD_SECTOR) begin
                  base = idx / SECTOR_SPAN * SECTOR_SPAN;
                  for (i = base; i < base + SECTOR_SPAN && i < ARRAY_WORDS; i++)
                     flash_mem[i] = '1;
                  n_erases++;
               end
               drop_to_read();
            end
            default: drop_to_read();
         endcase
      end
      r.command_phase = cur_phase;
      return r;
   endfunction

   function automatic stim_row_type row(bit fixed, logic mode,
                                        logic [nfc_pkg::ADDR_W-1:0] a,
                                        logic [nfc_pkg::DATA_W-1:0] d,
                                        logic [nfc_pkg::DATA_W-1:0] rd,
                                        nfc_pkg::phase_type ph);
      stim_row_type r;
      r.fixed = fixed;
      r.acc.mode = mode;
      r.acc.word_address = a;
      r.acc.write_data = d;
      r.want.read_data = rd;
      r.want.command_phase = ph;
      return r;
   endfunction

   function automatic logic [nfc_pkg::ADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 1) == 0)
         return nfc_pkg::ADDR_W'($urandom_range(0, 17'h1ffff));
      case ($urandom_range(0, 11))
         0: return 17'h00000;
         1: return nfc_pkg::ADDR_ID;
         2: return 17'h00002;
         3: return nfc_pkg::ADDR_FIRST;
         4: return nfc_pkg::ADDR_SECOND;
         5: return 17'h07fff;
         6: return 17'h08000;
         7: return 17'h0ffff;
         8: return 17'h10000;
         9: return 17'h17fff;
         10: return 17'h18000;
         default: return 17'h1ffff;
      endcase
   endfunction

   function automatic logic [nfc_pkg::DATA_W-1:0] pick_cmd();
      case ($urandom_range(0, 6))
         0: return nfc_pkg::CMD_UNLOCK1;
         1: return nfc_pkg::CMD_UNLOCK2;
         2: return nfc_pkg::CMD_PROGRAM;
         3: return nfc_pkg::CMD_ERASE;
         4: return nfc_pkg::CMD_SECTOR;
         5: return nfc_pkg::CMD_AUTOSEL;
         default: return nfc_pkg::CMD_RESET;
      endcase
   endfunction

   task automatic offer(nfc_pkg::req_payload_type acc, bit fixed,
                        nfc_pkg::rsp_payload_type want);
      int gap;
      nfc_pkg::rsp_payload_type got;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= acc;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      got = flash_access(acc);
      expect_q.push_back(fixed ? want : got);
      items_sent++;
   endtask

   task automatic access(logic mode, logic [nfc_pkg::ADDR_W-1:0] a,
                         logic [nfc_pkg::DATA_W-1:0] d);
      nfc_pkg::req_payload_type acc;
      acc.mode = mode;
      acc.word_address = a;
      acc.write_data = d;
      offer(acc, 1'b0, '0);
   endtask

   // sprinkle reads into command sequences: a read must not move the phase
   task automatic write_cmd(logic [nfc_pkg::ADDR_W-1:0] a, logic [nfc_pkg::DATA_W-1:0] d);
      if ($urandom_range(0, 9) == 0) access(1'b0, pick_addr(), $urandom());
      access(1'b1, a, d);
   endtask

   task automatic unlock();
      write_cmd(nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1);
      write_cmd(nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2);
   endtask

   task automatic run_sequence();
      logic [nfc_pkg::ADDR_W-1:0] sa [6];
      logic [nfc_pkg::DATA_W-1:0] sd [6];
      logic [nfc_pkg::ADDR_W-1:0] a;
      logic [nfc_pkg::DATA_W-1:0] d;
      int pick;
      int kind;
      int n;
      int cut;
      int reps;
      pick = $urandom_range(0, 99);
      if (pick < 3 && erases_left > 0) begin
         unlock();
         write_cmd(nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_ERASE);
         unlock();
         a = pick_addr();
         write_cmd(a, nfc_pkg::CMD_SECTOR);
         erases_left--;
         access(1'b0, a, $urandom());
      end else if (pick < 40) begin
         unlock();
         write_cmd(nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_PROGRAM);
         a = pick_addr();
         case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            2: d = nfc_pkg::CMD_RESET;
            3: d = pick_cmd();
            default: d = $urandom();
         endcase
         write_cmd(a, d);
         if ($urandom_range(0, 9) < 6) access(1'b0, a, $urandom());
      end else if (pick < 58) begin
         unlock();
         write_cmd(nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_AUTOSEL);
         reps = $urandom_range(1, 4);
         repeat (reps)
            access(1'b0, ($urandom_range(0, 2) == 0) ? pick_addr() : nfc_pkg::ADDR_ID,
                   $urandom());
         case ($urandom_range(0, 3))
            0: write_cmd(pick_addr(), nfc_pkg::CMD_RESET);
            1: begin
               access(1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1);
               access(1'b0, nfc_pkg::ADDR_ID, $urandom());
               write_cmd(pick_addr(), $urandom());
            end
            2: begin
               unlock();
               access(1'b0, nfc_pkg::ADDR_ID, $urandom());
               write_cmd(nfc_pkg::ADDR_FIRST, pick_cmd());
            end
            default: ;
         endcase
      end else if (pick < 75) begin
         // broken sequence: a valid prefix, then one step with a wrong address or word
         kind = $urandom_range(0, 2);
         sa[0] = nfc_pkg::ADDR_FIRST;
         sd[0] = nfc_pkg::CMD_UNLOCK1;
         sa[1] = nfc_pkg::ADDR_SECOND;
         sd[1] = nfc_pkg::CMD_UNLOCK2;
         sa[2] = nfc_pkg::ADDR_FIRST;
         case (kind)
            0: begin
               sd[2] = nfc_pkg::CMD_PROGRAM;
               n = 3;
            end
            1: begin
               sd[2] = nfc_pkg::CMD_AUTOSEL;
               n = 3;
            end
            default: begin
               sd[2] = nfc_pkg::CMD_ERASE;
               sa[3] = nfc_pkg::ADDR_FIRST;
               sd[3] = nfc_pkg::CMD_UNLOCK1;
               sa[4] = nfc_pkg::ADDR_SECOND;
               sd[4] = nfc_pkg::CMD_UNLOCK2;
               sa[5] = pick_addr();
               sd[5] = nfc_pkg::CMD_SECTOR;
               n = 6;
            end
         endcase
         cut = $urandom_range(0, n - 1);
         for (int i = 0; i < cut; i++) write_cmd(sa[i], sd[i]);
         if (cut == 5 || $urandom_range(0, 1) == 0) begin
            do d = ($urandom_range(0, 3) == 0) ? $urandom() : pick_cmd();
            while (d == sd[cut] || d == nfc_pkg::CMD_SECTOR);
            write_cmd(sa[cut], d);
         end else begin
            do a = pick_addr(); while (a == sa[cut]);
            write_cmd(a, sd[cut]);
         end
         if ($urandom_range(0, 1) == 0) access(1'b0, pick_addr(), $urandom());
      end else begin
         reps = $urandom_range(1, 3);
         repeat (reps) begin
            if ($urandom_range(0, 1) == 0) begin
               access(1'b0, pick_addr(), $urandom());
            end else begin
               case ($urandom_range(0, 5))
                  0: a = nfc_pkg::ADDR_FIRST;
                  1: a = nfc_pkg::ADDR_SECOND;
                  2: a = nfc_pkg::ADDR_ID;
                  default: a = pick_addr();
               endcase
               d = ($urandom_range(0, 9) < 3) ? pick_cmd() : $urandom();
               access(1'b1, a, d);
            end
         end
      end
   endtask

   task automatic set_device_id(logic [nfc_pkg::DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      device_id = value;
      n_id_writes++;
   endtask

   task automatic drain(int settle);
      int waited;
      waited = 0;
      while (expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request, check each transfer
   initial begin
      int stall;
      nfc_pkg::rsp_payload_type want;
      nfc_pkg::rsp_payload_type got;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending) begin
            stall = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 4);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = rsp_ch.payload;
         if (expect_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected response: read_data %h phase %0d",
                        got.read_data, got.command_phase);
         end else begin
            want = expect_q.pop_front();
            n_checked++;
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch on response %0d: expected %h phase %0d, got %h phase %0d",
                           n_checked, want.read_data, want.command_phase,
                           got.read_data, got.command_phase);
            end
         end
      end
   end

   initial begin
      stim_row_type script[$];
      int ph_start;
      foreach (flash_mem[i]) flash_mem[i] = '1;
      cur_phase = nfc_pkg::PH_READ;
      erase_aa_seen = 1'b0;
      id_mode = 1'b0;
      device_id = nfc_pkg::DEVICE_ID_RESET;
      steady = 1'b0;
      hold_pending = 1'b0;
      erases_left = 10;

      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;

      script.push_back(row(1, 1'b0, 17'h00000, 32'h0, 32'hffff_ffff, nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2, '0,
                           nfc_pkg::PH_UNLOCK2));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_PROGRAM, '0,
                           nfc_pkg::PH_PROGRAM));
      script.push_back(row(1, 1'b1, 17'h1ffff, 32'h1234_5678, '0, nfc_pkg::PH_READ));
      script.push_back(row(0, 1'b0, 17'h1ffff, 32'hffff_ffff, '0, nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2, '0,
                           nfc_pkg::PH_UNLOCK2));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_PROGRAM, '0,
                           nfc_pkg::PH_PROGRAM));
      script.push_back(row(1, 1'b1, 17'h00000, 32'h0, '0, nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2, '0,
                           nfc_pkg::PH_UNLOCK2));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_AUTOSEL, '0,
                           nfc_pkg::PH_AUTOSELECT));
      script.push_back(row(1, 1'b0, nfc_pkg::ADDR_ID, 32'h0, nfc_pkg::DEVICE_ID_RESET,
                           nfc_pkg::PH_AUTOSELECT));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b0, nfc_pkg::ADDR_ID, 32'hffff_ffff,
                           nfc_pkg::DEVICE_ID_RESET, nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_RESET, '0,
                           nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b0, nfc_pkg::ADDR_ID, 32'h0, 32'hffff_ffff,
                           nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_UNLOCK1));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2, '0,
                           nfc_pkg::PH_UNLOCK2));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_ERASE, '0,
                           nfc_pkg::PH_ERASE_SETUP));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_FIRST, nfc_pkg::CMD_UNLOCK1, '0,
                           nfc_pkg::PH_ERASE_SETUP));
      script.push_back(row(1, 1'b1, nfc_pkg::ADDR_SECOND, nfc_pkg::CMD_UNLOCK2, '0,
                           nfc_pkg::PH_ERASE_UNLOCK));
      script.push_back(row(1, 1'b1, 17'h1ffff, nfc_pkg::CMD_SECTOR, '0, nfc_pkg::PH_READ));
      script.push_back(row(1, 1'b0, 17'h1ffff, 32'h0, 32'hffff_ffff, nfc_pkg::PH_READ));
      script.push_back(row(0, 1'b0, 17'h00000, 32'hffff_ffff, '0, nfc_pkg::PH_READ));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) offer(script[i].acc, script[i].fixed, script[i].want);
      req_ch.valid <= 1'b0;
      drain(8);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_device_id('0);
            1: set_device_id('1);
            2: set_device_id($urandom());
            default: set_device_id(nfc_pkg::DEVICE_ID_RESET);
         endcase
         steady = (ph == 1);
         if (ph == 2) hold_pending = 1'b1;
         ph_start = items_sent;
         while (items_sent - ph_start < PHASE_ITEMS) run_sequence();
         req_ch.valid <= 1'b0;
         drain(8);
      end
      steady = 1'b0;
      drain(16);

      if (expect_q.size() != 0) begin
         $display("%0d expected responses never arrived", expect_q.size());
         errors += expect_q.size();
      end
      $display("Covered %0d accesses: %0d reads (%0d of the device ID), %0d writes,",
               items_sent, n_reads, n_id_reads, n_writes);
      $display("%0d programs, %0d sector erases, %0d device ID settings, %0d mismatches",
               n_programs, n_erases, n_id_writes, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
